// ----- src/rpa_pkg.sv -----
package rpa_pkg;

  // Request opcodes.
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_ADD_REF = 3'd2;
  localparam logic [2:0] OP_QUERY   = 3'd3;
  localparam logic [2:0] OP_INIT    = 3'd4;

  // Result status codes.
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_BAD_ADDR  = 3'd1;
  localparam logic [2:0] STATUS_NO_MEM    = 3'd2;
  localparam logic [2:0] STATUS_UNDERFLOW = 3'd3;
  localparam logic [2:0] STATUS_SATURATED = 3'd4;

  // Configuration register map (word index within the APB window).
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_WINDOW_BASE  = 2'd0;
  localparam logic [1:0] REG_FIRST_USABLE = 2'd1;
  localparam logic [1:0] REG_TOP_LIMIT    = 2'd2;

  localparam logic [31:0] WINDOW_BASE_RST  = 32'h8000_0000;
  localparam logic [31:0] FIRST_USABLE_RST = 32'h8000_0000;
  localparam logic [31:0] TOP_LIMIT_RST    = 32'h8800_0000;

  // One request transaction.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] phys_addr;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] page_addr;
    logic [7:0]  ref_count;
    logic        released;
  } rsp_t;

endpackage

// ----- src/rpa_ram.sv -----
module rpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/refcounted_page_allocator_top.sv -----
// Reference-counted physical page allocator.
// Requests enter on the in channel (valid/ready) as an opcode and a byte
// address: alloc, free, add-ref, query or init. Each request produces
// exactly one result transaction on the out channel (valid/ready) with a
// status, the allocated page address, the page's count and a released flag.
// The window base, first usable address and top limit are set through the
// APB port; write them only while no request is in flight.
// Alloc, free, add-ref and query take two steps each: the first checks the
// address and issues the memory reads, the second read-modify-writes the count
// memory and the free stack. A new request is taken only after the previous
// one has finished. Init first sets up the walk and its start index, then
// writes one stack entry and one count per cycle for each pushed page.
// A finished result sits in an output register; while the receiver stalls,
// the next request is still taken, and it waits in its final step until
// the output register frees up.
// After reset the count memory is cleared one entry per cycle; in_ready_o
// stays low during that pass.
module refcounted_page_allocator_top #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rpa_pkg::req_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rpa_pkg::rsp_t                     out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import rpa_pkg::*;

  localparam int unsigned IDX_W    = $clog2(NUM_PAGES);
  localparam int unsigned DEPTH_W  = $clog2(NUM_PAGES + 1);
  localparam int unsigned PB_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned SPAN_W   = ((IDX_W + PB_SHIFT) > 33) ? (IDX_W + PB_SHIFT) : 33;
  localparam int unsigned EXT_W    = SPAN_W + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
  localparam logic [32:0]           PB_33      = 33'(PAGE_BYTES);
  localparam logic [32:0]           PB_MASK_33 = ~(33'(PAGE_BYTES) - 33'd1);
  localparam logic [DEPTH_W-1:0]    DEPTH_FULL = DEPTH_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0]      IDX_LAST   = IDX_W'(NUM_PAGES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_INIT_START,
    ST_INIT_INDEX,
    ST_INIT_RUN
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [2:0]         op_q, op_d;
  logic               addr_ok_q, addr_ok_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [32:0]        p_q, p_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;

  logic [31:0] window_base_q, first_usable_q, top_limit_q;

  // Memory ports.
  logic                  cnt_we, stk_we;
  logic [IDX_W-1:0]      cnt_waddr, cnt_raddr, stk_waddr, stk_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [IDX_W-1:0]      stk_wdata, stk_rdata;

  // Address check on the incoming request.
  logic [32:0]      acc_off;
  logic [31:0]      acc_pg;
  logic             acc_ok;
  logic [IDX_W-1:0] acc_idx;

  always_comb begin
    acc_off = {1'b0, in_data_i.phys_addr} - {1'b0, window_base_q};
    acc_pg  = acc_off[31:0] >> PB_SHIFT;
    acc_idx = acc_pg[IDX_W-1:0];
    acc_ok  = (in_data_i.phys_addr[PB_SHIFT-1:0] == '0)
              && (in_data_i.phys_addr >= first_usable_q)
              && (in_data_i.phys_addr < top_limit_q)
              && !acc_off[32]
              && ({1'b0, acc_pg} < 33'(NUM_PAGES));
  end

  // Init walk bounds.
  logic [32:0]      fu_up, wb_up;
  logic [33:0]      p_next_end;
  logic [EXT_W-1:0] win_hi;
  logic             init_more;

  always_comb begin
    fu_up      = ({1'b0, first_usable_q} + (PB_33 - 33'd1)) & PB_MASK_33;
    wb_up      = ({1'b0, window_base_q} + (PB_33 - 33'd1)) & PB_MASK_33;
    p_next_end = {1'b0, p_q} + {1'b0, PB_33};
    win_hi     = EXT_W'(window_base_q) + (EXT_W'(NUM_PAGES) << PB_SHIFT);
    init_more  = (p_next_end <= {2'b00, top_limit_q}) && (EXT_W'(p_q) < win_hi);
  end

  // Read addresses: the count address is taken from the request while idle, then held; the stack is read at its top.
  assign cnt_raddr = (state_q == ST_IDLE) ? acc_idx : idx_q;
  assign stk_raddr = IDX_W'(depth_q - DEPTH_W'(1));

  // Sequencer and read-modify-write of the count memory and free stack.
  always_comb begin
    logic                  commit;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [31:0]           idx_ext;

    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    addr_ok_d   = addr_ok_q;
    idx_d       = idx_q;
    depth_d     = depth_q;
    p_d         = p_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = '0;
    stk_we    = 1'b0;
    stk_waddr = depth_q[IDX_W-1:0];
    stk_wdata = idx_q;

    commit  = !out_valid_q || out_ready_i;
    cnt_new = '0;
    idx_ext = 32'(stk_rdata);

    unique case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_data_i.opcode;
          addr_ok_d = acc_ok;
          idx_d     = acc_idx;
          state_d   = (in_data_i.opcode == OP_INIT) ? ST_INIT_START : ST_EXEC;
        end
      end

      ST_INIT_START: begin
        depth_d = '0;
        p_d     = (fu_up < wb_up) ? wb_up : fu_up;
        state_d = ST_INIT_INDEX;
      end

      ST_INIT_INDEX: begin
        idx_d   = IDX_W'((p_q - {1'b0, window_base_q}) >> PB_SHIFT);
        state_d = ST_INIT_RUN;
      end

      ST_INIT_RUN: begin
        if (init_more) begin
          cnt_we = 1'b1;
          if (depth_q < DEPTH_FULL) begin
            stk_we  = 1'b1;
            depth_d = depth_q + DEPTH_W'(1);
          end
          p_d   = p_q + PB_33;
          idx_d = idx_q + IDX_W'(1);
        end else begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (commit) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = ST_IDLE;
          unique case (op_q)
            OP_ALLOC: begin
              if (depth_q == '0) begin
                out_d.status = STATUS_NO_MEM;
              end else begin
                cnt_we          = 1'b1;
                cnt_waddr       = stk_rdata;
                cnt_wdata       = COUNT_ONE;
                depth_d         = depth_q - DEPTH_W'(1);
                out_d.page_addr = window_base_q + (idx_ext << PB_SHIFT);
                out_d.ref_count = 8'(COUNT_ONE);
              end
            end
            OP_FREE: begin
              if (!addr_ok_q) begin
                out_d.status = STATUS_BAD_ADDR;
              end else if (cnt_rdata == '0) begin
                out_d.status = STATUS_UNDERFLOW;
              end else begin
                cnt_new         = cnt_rdata - COUNT_ONE;
                cnt_we          = 1'b1;
                cnt_wdata       = cnt_new;
                out_d.ref_count = 8'(cnt_new);
                if (cnt_new == '0 && depth_q < DEPTH_FULL) begin
                  stk_we         = 1'b1;
                  depth_d        = depth_q + DEPTH_W'(1);
                  out_d.released = 1'b1;
                end
              end
            end
            OP_ADD_REF: begin
              if (!addr_ok_q) begin
                out_d.status = STATUS_BAD_ADDR;
              end else if (cnt_rdata == COUNT_MAX) begin
                out_d.status    = STATUS_SATURATED;
                out_d.ref_count = 8'(COUNT_MAX);
              end else begin
                cnt_new         = cnt_rdata + COUNT_ONE;
                cnt_we          = 1'b1;
                cnt_wdata       = cnt_new;
                out_d.ref_count = 8'(cnt_new);
              end
            end
            OP_QUERY: begin
              if (!addr_ok_q) begin
                out_d.status = STATUS_BAD_ADDR;
              end else begin
                out_d.ref_count = 8'(cnt_rdata);
              end
            end
            default: begin
              // Init and the unused opcodes answer all zero.
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_ALLOC;
      addr_ok_q   <= 1'b0;
      idx_q       <= '0;
      p_q         <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      addr_ok_q   <= addr_ok_d;
      idx_q       <= idx_d;
      p_q         <= p_d;
      out_q       <= out_d;
    end
  end

  // Configuration registers, written on the APB access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_base_q  <= WINDOW_BASE_RST;
      first_usable_q <= FIRST_USABLE_RST;
      top_limit_q    <= TOP_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_WINDOW_BASE:  window_base_q  <= pwdata;
        REG_FIRST_USABLE: first_usable_q <= pwdata;
        REG_TOP_LIMIT:    top_limit_q    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // APB read data.
  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_BASE:  prdata = window_base_q;
      REG_FIRST_USABLE: prdata = first_usable_q;
      REG_TOP_LIMIT:    prdata = top_limit_q;
      default:          prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Per-page reference counts.
  rpa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // Free page stack.
  rpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

endmodule

// ----- src/rpa_checker.sv -----
module rpa_props (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rpa_pkg::rsp_t out_data_o
);

  import rpa_pkg::*;

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Requests are worked one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in progress");

  // A bad address reports nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_BAD_ADDR |->
      out_data_o.page_addr == '0 && out_data_o.ref_count == '0 && !out_data_o.released)
    else $error("bad address result carries data");

  // A page is released only by a successful free that brought its count to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.released |->
      out_data_o.status == STATUS_OK && out_data_o.ref_count == '0
      && out_data_o.page_addr == '0)
    else $error("released flag on a result that is not a final free");

endmodule

bind refcounted_page_allocator_top rpa_props u_rpa_props (.*);
